/* rtl/srcd_pkg.sv */
package srcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 4;

  localparam logic [2:0] CMD_WRITE_BIT  = 3'd0;
  localparam logic [2:0] CMD_WRITE_BYTE = 3'd1;
  localparam logic [2:0] CMD_READ_BIT   = 3'd2;
  localparam logic [2:0] CMD_READ_BYTE  = 3'd3;
  localparam logic [2:0] CMD_FLUSH      = 3'd4;

  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_SERIAL = 1'b1;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] port_index;
    logic [2:0] register_index;
    logic [7:0] write_value;
    logic       shift_after;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] read_data;
    logic       serial_data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic busy;
    logic valid;
    logic serial_data;
    logic last;
  } ser_status_t;

endpackage

/* rtl/srcd_shadow.sv */
module srcd_shadow #(
  parameter int unsigned MAX_CHIPS = 8,
  parameter int unsigned IDX_W     = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              bit_we_i,
  input  logic                              byte_we_i,
  input  logic [IDX_W-1:0]                  wr_idx_i,
  input  logic [2:0]                        bit_pos_i,
  input  logic                              bit_val_i,
  input  logic [srcd_pkg::BYTE_W-1:0]       byte_val_i,
  input  logic [IDX_W-1:0]                  rd_idx_i,
  output logic [srcd_pkg::BYTE_W-1:0]       rd_data_o
);

  logic [srcd_pkg::BYTE_W-1:0] shadow_q [MAX_CHIPS];
  logic [srcd_pkg::BYTE_W-1:0] shadow_d [MAX_CHIPS];

  always_comb begin
    shadow_d = shadow_q;
    if (byte_we_i) begin
      shadow_d[wr_idx_i] = byte_val_i;
    end else if (bit_we_i) begin
      shadow_d[wr_idx_i][bit_pos_i] = bit_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHIPS; i++) begin
        shadow_q[i] <= '0;
      end
    end else begin
      shadow_q <= shadow_d;
    end
  end

  assign rd_data_o = shadow_q[rd_idx_i];

endmodule

/* rtl/srcd_ser.sv */
module srcd_ser #(
  parameter int unsigned IDX_W = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [IDX_W-1:0]             last_chip_i,
  input  logic [srcd_pkg::BYTE_W-1:0]  rd_data_i,
  output logic [IDX_W-1:0]             rd_idx_o,
  output srcd_pkg::ser_status_t        status_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [IDX_W-1:0]            cnt_q, cnt_d;
  logic [2:0]                  bit_q, bit_d;
  logic [srcd_pkg::BYTE_W-1:0] sr_q, sr_d;

  // fetch the current chip while loading, the next one down while shifting
  assign rd_idx_o = (state_q == ST_SHIFT && cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    sr_d    = sr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d   = last_chip_i;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        sr_d    = rd_data_i;
        bit_d   = 3'd7;
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (bit_q == 3'd0) begin
          if (cnt_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q - 1'b1;
            sr_d  = rd_data_i;
            bit_d = 3'd7;
          end
        end else begin
          sr_d  = {sr_q[srcd_pkg::BYTE_W-2:0], 1'b0};
          bit_d = bit_q - 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign status_o.busy        = (state_q != ST_IDLE);
  assign status_o.valid       = (state_q == ST_SHIFT);
  assign status_o.serial_data = sr_q[srcd_pkg::BYTE_W-1];
  assign status_o.last        = (state_q == ST_SHIFT) && (cnt_q == '0) && (bit_q == 3'd0);

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |=> state_q == ST_SHIFT && bit_q == 3'd7)
    else $error("shift did not begin at bit 7 after load");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.last |=> state_q == ST_IDLE)
    else $error("shift continued after last bit");

  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && start_i |=> state_q == ST_LOAD && cnt_q == $past(last_chip_i))
    else $error("shift start did not load chip count");

endmodule

/* rtl/shift_register_chain_driver_unit.sv */
// Driver for a daisy chain of 8-bit serial-in parallel-out output registers. Bit and
// byte writes, reads and writes without a shift leave busy_o low, and a read reply shows
// on res_o in the cycle after the request, with res_valid_o high for that single cycle.
// A flush, or a write with shift_after set (a bit write only if its port is in range),
// holds busy_o high while it fetches the first shadow byte and then sends 8*n bits, n
// being the chip count clamped to 1..MAX_CHIPS: one serial bit per cycle out of the
// 8-bit shift register, last chip first and MSB first, with last set on the final bit.
// Results are strobed and cannot be held off, so the receiver must take every strobed
// cycle. cfg_ready_o is always high; change the chip count only while busy_o is low.
module shift_register_chain_driver_unit #(
  parameter int unsigned MAX_CHIPS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  srcd_pkg::req_t               req_i,
  output logic                         res_valid_o,
  output srcd_pkg::res_t               res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [srcd_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam logic [srcd_pkg::CFG_W-1:0] MaxCount = srcd_pkg::CFG_W'(MAX_CHIPS);

  logic [srcd_pkg::CFG_W-1:0]  chip_count_q;
  logic [srcd_pkg::CFG_W-1:0]  last_chip;
  logic                        accept;
  logic                        port_ok, reg_ok;
  logic [IDX_W-1:0]            port_chip, reg_chip;
  logic                        bit_we, byte_we, do_shift;
  logic [IDX_W-1:0]            rd_idx, ser_idx;
  logic [srcd_pkg::BYTE_W-1:0] rd_data;
  logic                        rd_valid_q;
  logic [srcd_pkg::BYTE_W-1:0] rd_data_q, rd_data_d;
  srcd_pkg::ser_status_t       ser_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_count_q <= srcd_pkg::CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      chip_count_q <= cfg_data_i;
    end
  end

  // clamp the count to 1..MAX_CHIPS and keep the number of the last chip
  always_comb begin
    priority if (chip_count_q == '0) begin
      last_chip = '0;
    end else if (chip_count_q > MaxCount) begin
      last_chip = MaxCount - 1'b1;
    end else begin
      last_chip = chip_count_q - 1'b1;
    end
  end

  assign accept    = start_i && !busy_o;
  assign port_ok   = {1'b0, req_i.port_index[5:3]} <= last_chip;
  assign reg_ok    = {1'b0, req_i.register_index} <= last_chip;
  assign port_chip = IDX_W'(req_i.port_index[5:3]);
  assign reg_chip  = IDX_W'(req_i.register_index);

  assign bit_we  = accept && (req_i.cmd == srcd_pkg::CMD_WRITE_BIT) && port_ok;
  assign byte_we = accept && (req_i.cmd == srcd_pkg::CMD_WRITE_BYTE) && reg_ok;
  assign do_shift = accept && ((bit_we && req_i.shift_after)
                  || (req_i.cmd == srcd_pkg::CMD_WRITE_BYTE && req_i.shift_after)
                  || (req_i.cmd == srcd_pkg::CMD_FLUSH));

  // the shifter owns the read port while busy
  assign rd_idx = ser_st.busy ? ser_idx
                : (req_i.cmd == srcd_pkg::CMD_READ_BYTE) ? reg_chip : port_chip;

  srcd_shadow #(
    .MAX_CHIPS (MAX_CHIPS),
    .IDX_W     (IDX_W)
  ) u_shadow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bit_we_i   (bit_we),
    .byte_we_i  (byte_we),
    .wr_idx_i   (byte_we ? reg_chip : port_chip),
    .bit_pos_i  (req_i.port_index[2:0]),
    .bit_val_i  (req_i.write_value != '0),
    .byte_val_i (req_i.write_value),
    .rd_idx_i   (rd_idx),
    .rd_data_o  (rd_data)
  );

  srcd_ser #(
    .IDX_W (IDX_W)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (do_shift),
    .last_chip_i (IDX_W'(last_chip)),
    .rd_data_i   (rd_data),
    .rd_idx_o    (ser_idx),
    .status_o    (ser_st)
  );

  always_comb begin
    rd_data_d = '0;
    if (req_i.cmd == srcd_pkg::CMD_READ_BYTE) begin
      rd_data_d = reg_ok ? rd_data : '0;
    end else if (port_ok) begin
      rd_data_d = {7'd0, rd_data[req_i.port_index[2:0]]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= accept && (req_i.cmd == srcd_pkg::CMD_READ_BIT
                            || req_i.cmd == srcd_pkg::CMD_READ_BYTE);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= rd_data_d;
  end

  assign busy_o      = ser_st.busy;
  assign res_valid_o = rd_valid_q || ser_st.valid;

  always_comb begin
    if (rd_valid_q) begin
      res_o.kind        = srcd_pkg::KIND_READ;
      res_o.read_data   = rd_data_q;
      res_o.serial_data = 1'b0;
      res_o.last        = 1'b1;
    end else begin
      res_o.kind        = srcd_pkg::KIND_SERIAL;
      res_o.read_data   = '0;
      res_o.serial_data = ser_st.serial_data;
      res_o.last        = ser_st.last;
    end
  end

  a_no_result_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_valid_q && ser_st.valid))
    else $error("read reply and serial bit in the same cycle");

  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.cmd == srcd_pkg::CMD_FLUSH |=> busy_o && !res_valid_o)
    else $error("flush request did not start a shift");

  a_no_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !bit_we && !byte_we)
    else $error("shadow write while shifting");

endmodule

/* verif/tb_shift_register_chain_driver_unit.sv */
`timescale 1ns / 100ps

module tb_shift_register_chain_driver_unit;
  import srcd_pkg::*;

  localparam int unsigned MAX_CHIPS      = 8;
  localparam logic [2:0]  CMD_RSVD_5     = 3'd5;
  localparam logic [2:0]  CMD_RSVD_6     = 3'd6;
  localparam logic [2:0]  CMD_RSVD_7     = 3'd7;
  localparam int unsigned N_PHASES       = 12;
  localparam int unsigned REQS_PER_PHASE = 30;

  typedef struct {
    bit         is_cfg;
    logic [3:0] cfg;
    req_t       req;
    bit         typed;
    logic [7:0] exp_rd;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  req_t             req_i;
  logic             res_valid_o;
  res_t             res_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  // Shadow copy of the chain and the chip count as the block should hold them
  logic [7:0]  shadow_q [MAX_CHIPS];
  logic [3:0]  chip_count_q;
  res_t        pending_out_q [$];
  dir_row_t    dir_tab [$];
  res_t        head_r;
  int unsigned err_cnt;
  bit          no_idle;

  shift_register_chain_driver_unit #(
    .MAX_CHIPS(MAX_CHIPS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned chips_used();
    if (chip_count_q == 4'd0) return 1;
    if (chip_count_q > MAX_CHIPS) return MAX_CHIPS;
    return chip_count_q;
  endfunction

  function automatic res_t read_reply(logic [7:0] d);
    res_t r;
    r.kind        = KIND_READ;
    r.read_data   = d;
    r.serial_data = 1'b0;
    r.last        = 1'b1;
    return r;
  endfunction

  // Last chip first, MSB first; last marks the bit where the latch rises
  task automatic push_chain_shift();
    int unsigned n;
    res_t        r;
    n = chips_used();
    for (int j = 0; j < n; j++) begin
      for (int i = 7; i >= 0; i--) begin
        r.kind        = KIND_SERIAL;
        r.read_data   = 8'd0;
        r.serial_data = shadow_q[n - 1 - j][i];
        r.last        = (j == n - 1) && (i == 0);
        pending_out_q.push_back(r);
      end
    end
  endtask

  task automatic apply_chain_cmd(input req_t r);
    int unsigned n;
    logic        port_ok;
    logic        reg_ok;
    logic [2:0]  chip;
    logic [2:0]  pos;
    n       = chips_used();
    port_ok = r.port_index < n * 8;
    reg_ok  = r.register_index < n;
    chip    = r.port_index[5:3];
    pos     = r.port_index[2:0];
    case (r.cmd)
      CMD_WRITE_BIT: begin
        // out-of-range bit write is dropped along with its shift
        if (port_ok) begin
          shadow_q[chip][pos] = (r.write_value != 8'd0);
          if (r.shift_after) push_chain_shift();
        end
      end
      CMD_WRITE_BYTE: begin
        if (reg_ok) shadow_q[r.register_index] = r.write_value;
        if (r.shift_after) push_chain_shift();
      end
      CMD_READ_BIT: begin
        pending_out_q.push_back(read_reply(port_ok ? {7'd0, shadow_q[chip][pos]} : 8'd0));
      end
      CMD_READ_BYTE: begin
        pending_out_q.push_back(read_reply(reg_ok ? shadow_q[r.register_index] : 8'd0));
      end
      CMD_FLUSH: begin
        push_chain_shift();
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_req(input req_t r, input bit typed, input logic [7:0] exp_rd);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    // predict after the edge so the checker never sees a half-updated queue
    @(negedge clk_i);
    if (typed) pending_out_q.push_back(read_reply(exp_rd));
    else apply_chain_cmd(r);
  endtask

  task automatic idle_gap();
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_out_q.size() != 0) @(negedge clk_i);
    // writes without a shift leave nothing to wait on; give them time to retire
    repeat (3) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_chip_count(input logic [3:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i  <= 1'b0;
    chip_count_q = v;
  endtask

  function automatic req_t rand_req();
    req_t        r;
    int unsigned n;
    n = chips_used();
    if ($urandom_range(0, 99) < 8) r.cmd = 3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
    else r.cmd = 3'($urandom_range(CMD_WRITE_BIT, CMD_FLUSH));
    if ($urandom_range(0, 9) == 0) r.port_index = 6'($urandom_range(0, 63));
    else r.port_index = 6'($urandom_range(0, n * 8 - 1));
    if ($urandom_range(0, 9) == 0) r.register_index = 3'($urandom_range(0, 7));
    else r.register_index = 3'($urandom_range(0, n - 1));
    r.write_value = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    r.shift_after = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic dir_row_t req_row(logic [2:0] c, logic [5:0] p, logic [2:0] g,
                                       logic [7:0] v, logic s);
    dir_row_t d;
    d.is_cfg             = 1'b0;
    d.cfg                = 4'd0;
    d.req.cmd            = c;
    d.req.port_index     = p;
    d.req.register_index = g;
    d.req.write_value    = v;
    d.req.shift_after    = s;
    d.typed              = 1'b0;
    d.exp_rd             = 8'd0;
    return d;
  endfunction

  function automatic dir_row_t chk_row(logic [2:0] c, logic [5:0] p, logic [2:0] g,
                                       logic [7:0] rd);
    dir_row_t d;
    d        = req_row(c, p, g, 8'd0, 1'b0);
    d.typed  = 1'b1;
    d.exp_rd = rd;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic [3:0] v);
    dir_row_t d;
    d        = req_row(CMD_FLUSH, 6'd0, 3'd0, 8'd0, 1'b0);
    d.is_cfg = 1'b1;
    d.cfg    = v;
    return d;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_out_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected result kind=%0d rd=%02h sd=%0d last=%0d", $realtime,
                   res_o.kind, res_o.read_data, res_o.serial_data, res_o.last);
      end else begin
        head_r = pending_out_q.pop_front();
        if (res_o.kind !== head_r.kind || res_o.read_data !== head_r.read_data ||
            res_o.serial_data !== head_r.serial_data || res_o.last !== head_r.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: exp k=%0d rd=%02h sd=%0d l=%0d got k=%0d rd=%02h sd=%0d l=%0d",
                     $realtime, head_r.kind, head_r.read_data, head_r.serial_data,
                     head_r.last, res_o.kind, res_o.read_data, res_o.serial_data,
                     res_o.last);
        end
      end
    end
  end

  initial begin
    int unsigned w;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    err_cnt      = 0;
    no_idle      = 1'b0;
    chip_count_q = 4'd1;
    foreach (shadow_q[k]) shadow_q[k] = 8'd0;

    // one chip after reset
    dir_tab.push_back(chk_row(CMD_READ_BYTE, 6'd0, 3'd0, 8'd0));
    dir_tab.push_back(chk_row(CMD_READ_BIT, 6'd0, 3'd0, 8'd0));
    dir_tab.push_back(chk_row(CMD_READ_BYTE, 6'd0, 3'd7, 8'd0));
    dir_tab.push_back(chk_row(CMD_READ_BIT, 6'd63, 3'd0, 8'd0));
    dir_tab.push_back(req_row(CMD_WRITE_BYTE, 6'd0, 3'd0, 8'hff, 1'b0));
    dir_tab.push_back(chk_row(CMD_READ_BYTE, 6'd0, 3'd0, 8'hff));
    dir_tab.push_back(req_row(CMD_WRITE_BIT, 6'd0, 3'd0, 8'h00, 1'b1));
    dir_tab.push_back(req_row(CMD_WRITE_BIT, 6'd63, 3'd0, 8'h01, 1'b1));
    dir_tab.push_back(req_row(CMD_WRITE_BYTE, 6'd0, 3'd7, 8'ha5, 1'b1));
    dir_tab.push_back(req_row(CMD_RSVD_5, 6'd63, 3'd7, 8'hff, 1'b1));
    dir_tab.push_back(req_row(CMD_RSVD_7, 6'd0, 3'd0, 8'h00, 1'b0));
    dir_tab.push_back(req_row(CMD_WRITE_BIT, 6'd5, 3'd0, 8'h80, 1'b0));
    dir_tab.push_back(req_row(CMD_READ_BYTE, 6'd0, 3'd0, 8'h00, 1'b0));
    // full chain
    dir_tab.push_back(cfg_row(4'd8));
    dir_tab.push_back(req_row(CMD_WRITE_BYTE, 6'd0, 3'd7, 8'h81, 1'b1));
    dir_tab.push_back(req_row(CMD_WRITE_BIT, 6'd63, 3'd0, 8'h00, 1'b1));
    dir_tab.push_back(req_row(CMD_READ_BIT, 6'd63, 3'd0, 8'h00, 1'b0));
    dir_tab.push_back(req_row(CMD_FLUSH, 6'd0, 3'd0, 8'h00, 1'b0));
    // zero acts as one chip; an upper chip reads as zero but keeps its byte
    dir_tab.push_back(cfg_row(4'd0));
    dir_tab.push_back(req_row(CMD_FLUSH, 6'd0, 3'd0, 8'h00, 1'b0));
    dir_tab.push_back(chk_row(CMD_READ_BYTE, 6'd0, 3'd7, 8'd0));
    // above the maximum acts as a full chain
    dir_tab.push_back(cfg_row(4'd15));
    dir_tab.push_back(req_row(CMD_READ_BYTE, 6'd0, 3'd7, 8'h00, 1'b0));
    dir_tab.push_back(req_row(CMD_WRITE_BYTE, 6'd0, 3'd3, 8'h00, 1'b0));
    dir_tab.push_back(req_row(CMD_FLUSH, 6'd0, 3'd0, 8'h00, 1'b0));
    dir_tab.push_back(req_row(CMD_RSVD_6, 6'd10, 3'd2, 8'h3c, 1'b1));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        write_chip_count(dir_tab[k].cfg);
      end else begin
        send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].exp_rd);
        idle_gap();
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_chip_count(p == 0 ? 4'd1 : p == 1 ? 4'd8 : 4'($urandom_range(0, 15)));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < REQS_PER_PHASE; i++) begin
        send_req(rand_req(), 1'b0, 8'd0);
        // now and then hold off until the chain has fully drained
        if ($urandom_range(0, 19) == 0) wait_drained();
        else idle_gap();
      end
    end

    start_i <= 1'b0;
    for (w = 0; w < 20000 && pending_out_q.size() != 0; w++) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    err_cnt += pending_out_q.size();
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
